// ===== sv/dep_pkg.sv =====
// Package with shared types, sizes and codes of the double-ended priority queue.
`timescale 1ns / 1ps

package dep_pkg;

    // Queue size and the widths that follow from it.
    localparam int CAPACITY = 64;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = $clog2(CAPACITY);

    // Fixed field widths of the beats.
    localparam int ACT_W    = 2;
    localparam int VALUE_W  = 32;
    localparam int PRIO_W   = 24;
    localparam int STAT_W   = 2;
    localparam int ENTRY_W  = 7;

    // Action codes.
    localparam logic [ACT_W-1:0] ACT_INSERT  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_DEL_MIN = 2'd1;
    localparam logic [ACT_W-1:0] ACT_DEL_MAX = 2'd2;

    // Status codes.
    localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

    // One held entry of the sorted list.
    typedef struct packed {
        logic signed [PRIO_W-1:0] prio;
        logic [VALUE_W-1:0]       value;
    } t_entry;

    // Operation broadcast to every cell of the chain.
    typedef struct packed {
        logic ins;
        logic del_min;
    } t_cell_ctl;

endpackage

// ===== sv/dep_if.sv =====
// Request and response channel interfaces of the double-ended priority queue.
`timescale 1ns / 1ps

interface dep_req_if;
    logic                            valid;
    logic                            ready;
    logic [dep_pkg::ACT_W-1:0]       action;
    logic [dep_pkg::VALUE_W-1:0]     item_value;
    logic signed [dep_pkg::PRIO_W-1:0] priority_req;

    modport source (output valid, output action, output item_value,
                    output priority_req, input ready);
    modport sink   (input valid, input action, input item_value,
                    input priority_req, output ready);
endinterface

interface dep_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [dep_pkg::STAT_W-1:0]        status;
    logic [dep_pkg::VALUE_W-1:0]       removed_value;
    logic signed [dep_pkg::PRIO_W-1:0] removed_priority;
    logic [dep_pkg::ENTRY_W-1:0]       entry_count;
    logic [dep_pkg::VALUE_W-1:0]       min_value;
    logic [dep_pkg::VALUE_W-1:0]       max_value;
    logic                              has_entries;

    modport source (output valid, output status, output removed_value,
                    output removed_priority, output entry_count, output min_value,
                    output max_value, output has_entries, input ready);
    modport sink   (input valid, input status, input removed_value,
                    input removed_priority, input entry_count, input min_value,
                    input max_value, input has_entries, output ready);
endinterface

// ===== sv/dep_cell.sv =====
// One compare-and-shift cell of the sorted chain.
`timescale 1ns / 1ps

module dep_cell (
    input  logic               i_clk,
    input  dep_pkg::t_cell_ctl i_ctl,
    input  dep_pkg::t_entry    i_new,
    input  dep_pkg::t_entry    i_left,
    input  dep_pkg::t_entry    i_right,
    input  logic               i_left_gt,
    input  logic               i_occupied,
    output dep_pkg::t_entry    o_entry,
    output logic               o_gt
);
    import dep_pkg::*;

    t_entry r_entry;
    t_entry n_entry;

    // An empty cell counts as greater, so the first empty cell takes the new entry
    // when no held entry outranks it.
    assign o_gt = !i_occupied || ($signed(r_entry.prio) > $signed(i_new.prio));

    // Insert: the first greater cell takes the new entry, later ones shift up.
    // Delete-min: every cell takes its right neighbor; the top cell keeps its own entry.
    always_comb begin
        n_entry = r_entry;
        if (i_ctl.ins) begin
            if (o_gt && i_left_gt) begin
                n_entry = i_left;
            end else if (o_gt) begin
                n_entry = i_new;
            end
        end else if (i_ctl.del_min) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

// ===== sv/dep_chain.sv =====
// Row of sorted cells with neighbor wiring and occupancy from the count.
`timescale 1ns / 1ps

module dep_chain (
    input  logic                                   i_clk,
    input  dep_pkg::t_cell_ctl                     i_ctl,
    input  dep_pkg::t_entry                        i_new,
    input  logic [dep_pkg::CNT_W-1:0]              i_count,
    output dep_pkg::t_entry [dep_pkg::CAPACITY-1:0] o_entries
);
    import dep_pkg::*;

    t_entry [CAPACITY-1:0] w_entries;
    logic   [CAPACITY-1:0] w_gt;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            t_entry w_left;
            t_entry w_right;
            logic   w_left_gt;
            logic   w_occupied;

            // The low end has no left neighbor; the high end has no right one.
            if (g == 0) begin : g_lo
                assign w_left    = i_new;
                assign w_left_gt = 1'b0;
            end else begin : g_mid_lo
                assign w_left    = w_entries[g-1];
                assign w_left_gt = w_gt[g-1];
            end
            if (g == CAPACITY - 1) begin : g_hi
                assign w_right = w_entries[g];
            end else begin : g_mid_hi
                assign w_right = w_entries[g+1];
            end

            assign w_occupied = (CNT_W'(g) < i_count);

            dep_cell u_cell (
                .i_clk      (i_clk),
                .i_ctl      (i_ctl),
                .i_new      (i_new),
                .i_left     (w_left),
                .i_right    (w_right),
                .i_left_gt  (w_left_gt),
                .i_occupied (w_occupied),
                .o_entry    (w_entries[g]),
                .o_gt       (w_gt[g])
            );
        end
    endgenerate

    assign o_entries = w_entries;

endmodule

// ===== sv/double_ended_priority_queue.sv =====
// Throughput: one request per cycle unless stalled; every cell compares and shifts
// in the same cycle. Results pass the operation stage, then the response register.
// The request side stalls only while both stages hold beats and the response is not taken.
// Reset clears the entry count and both pipeline stages; the list reads as empty.
// Cell contents are not cleared and are never shown until written.
`timescale 1ns / 1ps

module double_ended_priority_queue (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dep_req_if.sink    i_req,
    dep_rsp_if.source  o_rsp
);
    import dep_pkg::*;

    t_entry [CAPACITY-1:0] w_entries;
    t_cell_ctl             w_ctl;
    t_entry                w_new;
    logic                  w_accept;
    logic                  w_a_move;
    logic                  w_full;
    logic                  w_empty;
    logic [IDX_W-1:0]      w_tail_idx;
    logic [STAT_W-1:0]     w_status;
    t_entry                w_removed;

    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;
    logic                  r_a_valid;
    logic [STAT_W-1:0]     r_a_status;
    t_entry                r_a_removed;
    logic                  r_o_valid;
    logic [STAT_W-1:0]     r_o_status;
    t_entry                r_o_removed;
    logic [CNT_W-1:0]      r_o_count;
    logic [VALUE_W-1:0]    r_o_min;
    logic [VALUE_W-1:0]    r_o_max;

    // Handshake: the operation stage frees when the response register can load.
    assign w_a_move    = r_a_valid && (!r_o_valid || o_rsp.ready);
    assign i_req.ready = !r_a_valid || w_a_move;
    assign w_accept    = i_req.valid && i_req.ready;

    assign w_full     = (r_count == CNT_W'(CAPACITY));
    assign w_empty    = (r_count == '0);
    assign w_tail_idx = IDX_W'(r_count - CNT_W'(1));

    assign w_new.prio  = i_req.priority_req;
    assign w_new.value = i_req.item_value;

    // Decode the request into cell controls, status, removed entry and new count.
    always_comb begin
        w_ctl     = '0;
        w_status  = STAT_DONE;
        w_removed = '0;
        n_count   = r_count;
        unique case (i_req.action)
            ACT_INSERT: begin
                if (w_full) begin
                    w_status = STAT_FULL;
                end else begin
                    w_ctl.ins = w_accept;
                    n_count   = r_count + CNT_W'(1);
                end
            end
            ACT_DEL_MIN: begin
                if (w_empty) begin
                    w_status = STAT_EMPTY;
                end else begin
                    w_ctl.del_min = w_accept;
                    w_removed     = w_entries[0];
                    n_count       = r_count - CNT_W'(1);
                end
            end
            ACT_DEL_MAX: begin
                if (w_empty) begin
                    w_status = STAT_EMPTY;
                end else begin
                    w_removed = w_entries[w_tail_idx];
                    n_count   = r_count - CNT_W'(1);
                end
            end
            default: begin
                w_status = STAT_DONE;
            end
        endcase
    end

    dep_chain u_chain (
        .i_clk     (i_clk),
        .i_ctl     (w_ctl),
        .i_new     (w_new),
        .i_count   (r_count),
        .o_entries (w_entries)
    );

    // Control state: count and stage valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_a_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count <= n_count;
            end
            if (w_accept) begin
                r_a_valid <= 1'b1;
            end else if (w_a_move) begin
                r_a_valid <= 1'b0;
            end
            if (w_a_move) begin
                r_o_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Payload: the operation stage, then the response register that reads both ends
    // of the list once the operation has settled into the cells.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_a_status  <= w_status;
            r_a_removed <= w_removed;
        end
        if (w_a_move) begin
            r_o_status  <= r_a_status;
            r_o_removed <= r_a_removed;
            r_o_count   <= r_count;
            r_o_min     <= w_empty ? '0 : w_entries[0].value;
            r_o_max     <= w_empty ? '0 : w_entries[w_tail_idx].value;
        end
    end

    assign o_rsp.valid            = r_o_valid;
    assign o_rsp.status           = r_o_status;
    assign o_rsp.removed_value    = r_o_removed.value;
    assign o_rsp.removed_priority = r_o_removed.prio;
    assign o_rsp.entry_count      = ENTRY_W'(r_o_count);
    assign o_rsp.min_value        = r_o_min;
    assign o_rsp.max_value        = r_o_max;
    assign o_rsp.has_entries      = (r_o_count != '0);

endmodule
